[rtl/core/inertial_scroll_decay_core_assert.svh]
// Assertion macros used by the inertial scroll decay checker.
`ifndef INERTIAL_SCROLL_DECAY_CORE_ASSERT_SVH
`define INERTIAL_SCROLL_DECAY_CORE_ASSERT_SVH

// Property checked on every clock edge outside of reset.
`define ISD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("inertial scroll decay check failed");

// Property checked on every clock edge, reset included.
`define ISD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("inertial scroll decay check failed");

`endif

[rtl/core/isd_pkg.sv]
// Shared types and constants of the inertial scroll decay core.
package isd_pkg;

   typedef enum logic [1:0] {
      KIND_DELTA  = 2'd0,
      KIND_LIFT   = 2'd1,
      KIND_CANCEL = 2'd2,
      KIND_TICK   = 2'd3
   } kind_type;

   localparam logic [2:0] CSR_NATURAL_DIRECTION = 3'd0;
   localparam logic [2:0] CSR_HORIZONTAL_ENABLE = 3'd1;
   localparam logic [2:0] CSR_INERTIA_ENABLE    = 3'd2;
   localparam logic [2:0] CSR_VERTICAL_GAIN     = 3'd3;
   localparam logic [2:0] CSR_HORIZONTAL_GAIN   = 3'd4;
   localparam logic [2:0] CSR_SPEED_LIMIT       = 3'd5;
   localparam logic [2:0] CSR_DECAY_FACTOR      = 3'd6;
   localparam logic [2:0] CSR_STOP_THRESHOLD    = 3'd7;

   localparam logic [11:0] GAIN_RESET      = 12'd256;
   localparam logic [14:0] LIMIT_RESET     = 15'd32767;
   localparam logic [15:0] DECAY_RESET     = 16'd62259;
   localparam logic [14:0] THRESHOLD_RESET = 15'd128;

   // Everything one axis can produce for the current request.
   typedef struct packed {
      logic signed [15:0] delta;   // scaled and saturated scroll amount
      logic signed [15:0] lift;    // scaled and clamped launch velocity
      logic signed [15:0] coast;   // decayed velocity, zero once stopped
      logic               stopped; // decayed magnitude fell below threshold
   } axis_result_type;

endpackage

[rtl/core/isd_axis.sv]
// Per-axis datapath: direction, gain, saturation, clamp and velocity decay.
module isd_axis
   import isd_pkg::*;
(
   input  logic signed [15:0] sample,
   input  logic signed [15:0] velocity,
   input  logic               negate,
   input  logic               enable,
   input  logic        [11:0] gain,
   input  logic        [14:0] speed_limit,
   input  logic        [15:0] decay_factor,
   input  logic        [14:0] stop_threshold,
   output axis_result_type    result
);

   logic signed [16:0] dir_value;
   logic signed [29:0] gain_prod;
   logic signed [21:0] scaled;
   logic signed [21:0] limit_pos;
   logic signed [21:0] limit_neg;
   logic signed [32:0] decay_prod;
   logic signed [15:0] decayed;
   logic signed [16:0] decayed_ext;
   logic        [16:0] magnitude;
   logic signed [15:0] delta_sat;
   logic signed [15:0] lift_clamp;
   logic signed [15:0] coast_value;
   logic               below_stop;

   // Widen before negating so that the most negative input stays exact.
   always_comb begin
      dir_value = {sample[15], sample};
      if (negate) begin
         dir_value = -dir_value;
      end
      if (!enable) begin
         dir_value = '0;
      end
   end

   assign gain_prod = dir_value * $signed({1'b0, gain});
   assign scaled    = gain_prod[29:8];
   assign limit_pos = $signed({7'b0, speed_limit});
   assign limit_neg = -limit_pos;

   always_comb begin
      priority if (scaled > 22'sd32767) begin
         delta_sat = 16'sh7FFF;
      end else if (scaled < -22'sd32768) begin
         delta_sat = 16'sh8000;
      end else begin
         delta_sat = scaled[15:0];
      end
   end

   always_comb begin
      priority if (scaled > limit_pos) begin
         lift_clamp = limit_pos[15:0];
      end else if (scaled < limit_neg) begin
         lift_clamp = limit_neg[15:0];
      end else begin
         lift_clamp = scaled[15:0];
      end
   end

   // The decay factor is below one, so the floored product fits 16 bits.
   assign decay_prod  = velocity * $signed({1'b0, decay_factor});
   assign decayed     = decay_prod[31:16];
   assign decayed_ext = {decayed[15], decayed};
   assign magnitude   = decayed_ext[16] ? 17'(-decayed_ext) : 17'(decayed_ext);

   assign below_stop  = magnitude < {2'b0, stop_threshold};
   assign coast_value = below_stop ? 16'sd0 : decayed;

   // Field order follows the struct: delta, lift, coast, stopped.
   assign result = {delta_sat, lift_clamp, coast_value, below_stop};

endmodule

[rtl/core/inertial_scroll_decay_core.sv]
// Top level of the two-axis kinetic scroll engine with exponential velocity decay.
// A request waits in the request register; a delta, or a tick that keeps coasting, writes the result register.
// Throughput: one request per cycle; the only stall comes from a held result.
// The per-axis multipliers sit between the request register and the result register.
// Reset is synchronous and active high; it clears coasting, both velocities and
// every pending request, and restores the register defaults.
module inertial_scroll_decay_core
   import isd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [15:0] vert_value, [31:16] horz_value
   input  logic [1:0]  req_tuser,  // [1:0] kind
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [15:0] out_vert, [31:16] out_horz
   // Register write port.
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Register file.
   logic        natural_ff;
   logic        horz_enable_ff;
   logic        inertia_ff;
   logic [11:0] vert_gain_ff;
   logic [11:0] horz_gain_ff;
   logic [14:0] limit_ff;
   logic [15:0] decay_ff;
   logic [14:0] threshold_ff;

   // Request register.
   logic               in_valid_ff;
   kind_type           in_kind_ff;
   logic signed [15:0] in_vert_ff;
   logic signed [15:0] in_horz_ff;

   // Coasting state.
   logic               coast_ff, coast_in;
   logic signed [15:0] vert_vel_ff, vert_vel_in;
   logic signed [15:0] horz_vel_ff, horz_vel_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_vert_ff, rsp_vert_in;
   logic signed [15:0] rsp_horz_ff, rsp_horz_in;

   logic            fire;
   logic            emit;
   axis_result_type vert_res;
   axis_result_type horz_res;

   // The held request is processed whenever the result register is free or
   // is being emptied in this cycle, so a new request can follow every cycle.
   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_horz_ff, rsp_vert_ff};

   isd_axis u_vert (
      .sample         (in_vert_ff),
      .velocity       (vert_vel_ff),
      .negate         (natural_ff),
      .enable         (1'b1),
      .gain           (vert_gain_ff),
      .speed_limit    (limit_ff),
      .decay_factor   (decay_ff),
      .stop_threshold (threshold_ff),
      .result         (vert_res)
   );

   isd_axis u_horz (
      .sample         (in_horz_ff),
      .velocity       (horz_vel_ff),
      .negate         (natural_ff),
      .enable         (horz_enable_ff),
      .gain           (horz_gain_ff),
      .speed_limit    (limit_ff),
      .decay_factor   (decay_ff),
      .stop_threshold (threshold_ff),
      .result         (horz_res)
   );

   // Event handling. State is updated in the same cycle that the request
   // leaves the request register, so the next request already sees it.
   always_comb begin
      emit        = 1'b0;
      coast_in    = coast_ff;
      vert_vel_in = vert_vel_ff;
      horz_vel_in = horz_vel_ff;
      rsp_vert_in = vert_res.delta;
      rsp_horz_in = horz_res.delta;
      if (fire) begin
         unique case (in_kind_ff)
            KIND_DELTA: begin
               emit = 1'b1;
            end
            KIND_LIFT: begin
               // With inertia off a lift behaves like a cancel.
               coast_in    = inertia_ff;
               vert_vel_in = inertia_ff ? vert_res.lift : 16'sd0;
               horz_vel_in = inertia_ff ? horz_res.lift : 16'sd0;
            end
            KIND_CANCEL: begin
               coast_in    = 1'b0;
               vert_vel_in = 16'sd0;
               horz_vel_in = 16'sd0;
            end
            KIND_TICK: begin
               if (coast_ff) begin
                  vert_vel_in = vert_res.coast;
                  horz_vel_in = horz_res.coast;
                  rsp_vert_in = vert_res.coast;
                  rsp_horz_in = horz_res.coast;
                  // Coasting ends silently once both axes have died out.
                  if (vert_res.stopped && horz_res.stopped) begin
                     coast_in = 1'b0;
                  end else begin
                     emit = 1'b1;
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         natural_ff     <= 1'b0;
         horz_enable_ff <= 1'b1;
         inertia_ff     <= 1'b1;
         vert_gain_ff   <= GAIN_RESET;
         horz_gain_ff   <= GAIN_RESET;
         limit_ff       <= LIMIT_RESET;
         decay_ff       <= DECAY_RESET;
         threshold_ff   <= THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NATURAL_DIRECTION: natural_ff     <= csr_wdata[0];
            CSR_HORIZONTAL_ENABLE: horz_enable_ff <= csr_wdata[0];
            CSR_INERTIA_ENABLE:    inertia_ff     <= csr_wdata[0];
            CSR_VERTICAL_GAIN:     vert_gain_ff   <= csr_wdata[11:0];
            CSR_HORIZONTAL_GAIN:   horz_gain_ff   <= csr_wdata[11:0];
            CSR_SPEED_LIMIT:       limit_ff       <= csr_wdata[14:0];
            CSR_DECAY_FACTOR:      decay_ff       <= csr_wdata;
            CSR_STOP_THRESHOLD:    threshold_ff   <= csr_wdata[14:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         coast_ff     <= 1'b0;
         vert_vel_ff  <= 16'sd0;
         horz_vel_ff  <= 16'sd0;
      end else begin
         in_valid_ff  <= req_tvalid || !req_tready;
         rsp_valid_ff <= rsp_valid_in;
         coast_ff     <= coast_in;
         vert_vel_ff  <= vert_vel_in;
         horz_vel_ff  <= horz_vel_in;
      end
   end

   // Payload registers load without reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= kind_type'(req_tuser);
         in_vert_ff <= req_tdata[15:0];
         in_horz_ff <= req_tdata[31:16];
      end
      if (fire && emit) begin
         rsp_vert_ff <= rsp_vert_in;
         rsp_horz_ff <= rsp_horz_in;
      end
   end

endmodule

[rtl/core/isd_checker.sv]
// Port-level checker for the inertial scroll decay core, bound to the top level.
`include "inertial_scroll_decay_core_assert.svh"

module isd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   logic rsp_stall;
   logic req_fire;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_fire  = req_tvalid && req_tready;

   `ISD_ASSERT_ALWAYS(a_reset_clears_result, clock, reset |=> !rsp_tvalid)

   `ISD_ASSERT(a_result_holds, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata))

   `ISD_ASSERT(a_result_follows_request, clock, reset, $rose(rsp_tvalid) |-> $past(req_fire, 2))

endmodule

bind inertial_scroll_decay_core isd_checker u_isd_checker (.*);
